/* hw/rtl/mcl_pkg.sv */
// shared constants and types for the morse code lock
`timescale 1ns / 1ps

package mcl_pkg;

    localparam int CODE_BITS     = 8;
    localparam int VIEW_BITS     = 8;
    localparam int TICK_BITS     = 16;
    localparam int CMD_BITS      = 2;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CODE_BITS-1:0] STORED_CODE_RESET = CODE_BITS'(8'h0A);
    localparam logic [TICK_BITS-1:0] HOLD_TICKS_RESET  = TICK_BITS'(200);
    localparam logic [TICK_BITS-1:0] OPEN_TICKS_RESET  = TICK_BITS'(500);

    // event codes
    localparam logic [CMD_BITS-1:0] CMD_PRESS   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_TICKS = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OPEN_TICKS = 1'd1;

    typedef struct packed {
        logic                 door_open;
        logic [VIEW_BITS-1:0] stored_code_view;
        logic [VIEW_BITS-1:0] entered_code_view;
        logic                 programming_mode;
        logic                 long_press;
    } mcl_result_t;

endpackage

/* hw/rtl/mcl_in_if.sv */
// event request channel
`timescale 1ns / 1ps

interface mcl_in_if
    import mcl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] cmd;
    logic                authorized;

    modport source (output valid, output cmd, output authorized, input ready);
    modport sink   (input valid, input cmd, input authorized, output ready);
endinterface

/* hw/rtl/mcl_out_if.sv */
// result request channel
`timescale 1ns / 1ps

interface mcl_out_if
    import mcl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 door_open;
    logic [VIEW_BITS-1:0] stored_code_view;
    logic [VIEW_BITS-1:0] entered_code_view;
    logic                 programming_mode;
    logic                 long_press;

    modport source (
        output valid, output door_open, output stored_code_view,
        output entered_code_view, output programming_mode, output long_press,
        input ready
    );
    modport sink (
        input valid, input door_open, input stored_code_view,
        input entered_code_view, input programming_mode, input long_press,
        output ready
    );
endinterface

/* hw/rtl/morse_code_lock_unit.sv */
// morse code lock: event handling, configuration registers and result buffering
`timescale 1ns / 1ps

// a result shows the lock state after its event and is registered when the event request is accepted
// throughput: one event per cycle while the skid entry is empty; the state update is a single pass of
//   compare, shift and 16-bit increment logic into the lock state registers
// results sit in an output register backed by one skid entry
// reset: codes, timers and flags clear, stored code loads 0x0A,
//   hold_ticks loads 200 and open_ticks loads 500

module morse_code_lock_unit
    import mcl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    mcl_in_if.sink                   events,
    mcl_out_if.source                results
);

    // configuration
    logic [TICK_BITS-1:0] hold_ticks_reg;
    logic [TICK_BITS-1:0] open_ticks_reg;

    // lock state
    logic [CODE_BITS-1:0] stored_code_reg,  stored_code_next;
    logic [CODE_BITS-1:0] entered_code_reg, entered_code_next;
    logic [TICK_BITS-1:0] tick_count_reg,   tick_count_next;
    logic                 timer_on_reg,     timer_on_next;
    logic                 held_long_reg,    held_long_next;
    logic                 door_flag_reg,    door_flag_next;
    logic                 reprog_reg,       reprog_next;

    // result buffering
    logic        out_valid_reg;
    mcl_result_t out_data_reg;
    logic        skid_valid_reg;
    mcl_result_t skid_data_reg;

    logic                 in_fire;
    logic                 out_fire;
    logic [TICK_BITS-1:0] tick_inc;
    logic [CODE_BITS-1:0] entered_shift;
    logic [CODE_BITS-1:0] stored_shift;
    mcl_result_t          result;

    // one skid entry lets a request in while a result waits downstream
    assign events.ready = !skid_valid_reg;
    assign in_fire      = events.valid && events.ready;
    assign out_fire     = results.valid && results.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_TICKS_RESET;
            open_ticks_reg <= OPEN_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_HOLD_TICKS: hold_ticks_reg <= TICK_BITS'(cfg_data);
                REG_OPEN_TICKS: open_ticks_reg <= TICK_BITS'(cfg_data);
                default:        ;
            endcase
        end
    end

    // shift the press length into a code, oldest bit falls off the top
    assign tick_inc      = tick_count_reg + TICK_BITS'(1);
    assign entered_shift = {entered_code_reg[CODE_BITS-2:0], held_long_reg};
    assign stored_shift  = {stored_code_reg[CODE_BITS-2:0], held_long_reg};

    // next lock state for the accepted event
    always_comb
    begin
        stored_code_next  = stored_code_reg;
        entered_code_next = entered_code_reg;
        tick_count_next   = tick_count_reg;
        timer_on_next     = timer_on_reg;
        held_long_next    = held_long_reg;
        door_flag_next    = door_flag_reg;
        reprog_next       = reprog_reg;

        if (in_fire)
        begin
            case (events.cmd)
                CMD_PRESS:
                begin
                    // key presses are ignored while the door is open
                    if (!door_flag_reg)
                    begin
                        timer_on_next   = 1'b1;
                        held_long_next  = 1'b0;
                        tick_count_next = '0;
                        if (events.authorized)
                        begin
                            // first press under the switch wipes both codes
                            if (!reprog_reg)
                            begin
                                reprog_next       = 1'b1;
                                entered_code_next = '0;
                                stored_code_next  = '0;
                            end
                        end
                        else
                        begin
                            reprog_next = 1'b0;
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    if (!door_flag_reg)
                    begin
                        if (events.authorized)
                        begin
                            stored_code_next = stored_shift;
                        end
                        else
                        begin
                            entered_code_next = entered_shift;
                            // code match opens the door and restarts the timer
                            if (entered_shift == stored_code_reg)
                            begin
                                door_flag_next  = 1'b1;
                                timer_on_next   = 1'b1;
                                held_long_next  = 1'b0;
                                tick_count_next = '0;
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (timer_on_reg)
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc == hold_ticks_reg && !door_flag_reg)
                        begin
                            timer_on_next  = 1'b0;
                            held_long_next = 1'b1;
                        end
                        // door closes after open_ticks, entry starts over
                        if (tick_inc == open_ticks_reg && door_flag_reg)
                        begin
                            timer_on_next     = 1'b0;
                            door_flag_next    = 1'b0;
                            entered_code_next = '0;
                        end
                    end
                end
                default:
                begin
                    // unused code leaves the state alone
                end
            endcase
        end
    end

    // result shows the state after the event
    always_comb
    begin
        result.door_open         = door_flag_next;
        result.stored_code_view  = VIEW_BITS'(stored_code_next);
        result.entered_code_view = VIEW_BITS'(entered_code_next);
        result.programming_mode  = reprog_next;
        result.long_press        = held_long_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_code_reg  <= STORED_CODE_RESET;
            entered_code_reg <= '0;
            tick_count_reg   <= '0;
            timer_on_reg     <= 1'b0;
            held_long_reg    <= 1'b0;
            door_flag_reg    <= 1'b0;
            reprog_reg       <= 1'b0;
        end
        else
        begin
            stored_code_reg  <= stored_code_next;
            entered_code_reg <= entered_code_next;
            tick_count_reg   <= tick_count_next;
            timer_on_reg     <= timer_on_next;
            held_long_reg    <= held_long_next;
            door_flag_reg    <= door_flag_next;
            reprog_reg       <= reprog_next;
        end
    end

    // output register and skid entry control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_fire)
            begin
                out_data_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_data_reg <= result;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.door_open         = out_data_reg.door_open;
    assign results.stored_code_view  = out_data_reg.stored_code_view;
    assign results.entered_code_view = out_data_reg.entered_code_view;
    assign results.programming_mode  = out_data_reg.programming_mode;
    assign results.long_press        = out_data_reg.long_press;

    // skid entry only fills behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result with the output register empty");

    // a press with the door shut restarts timing and clears the long flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && events.cmd == CMD_PRESS && !door_flag_reg)
            |=> (timer_on_reg && !held_long_reg && tick_count_reg == '0))
        else $error("press did not restart the press timer");

    // the door only opens on an accepted key release
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(door_flag_reg) |-> $past(in_fire && events.cmd == CMD_RELEASE))
        else $error("door opened without a key release");

endmodule
